FILE: rtl/aesbc_pkg.sv
// Shared constants, tables, types and byte functions of the AES block cipher.
`default_nettype none
package aesbc_pkg;

    localparam int MAX_ROUNDS = 14;
    localparam int RK_ROWS    = MAX_ROUNDS + 1;
    localparam int RK_AW      = $clog2(RK_ROWS);
    localparam int RK_WORDS   = 4 * RK_ROWS;
    localparam int RK_WAW     = $clog2(RK_WORDS);

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;

    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_KLEN  = 3'd4;
    localparam logic [2:0] REG_CHAIN = 3'd5;
    localparam logic [2:0] REG_IVH   = 3'd6;
    localparam logic [2:0] REG_IVL   = 3'd7;

    localparam logic [2047:0] SBOX_V = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

    localparam logic [2047:0] ISBOX_V = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

    typedef enum logic [1:0] {
        RK_FIRST = 2'd0,
        RK_MID   = 2'd1,
        RK_LAST  = 2'd2
    } round_kind_t;

    typedef struct packed {
        logic             we;
        logic [RK_AW-1:0] addr;
        logic [127:0]     data;
    } rk_wr_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX_V[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] isbox(input logic [7:0] x);
        return ISBOX_V[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [3:0] nk_of(input logic [1:0] mode);
        case (mode)
            KEY_128: return 4'd4;
            KEY_192: return 4'd6;
            default: return 4'd8;
        endcase
    endfunction

    function automatic logic [RK_AW-1:0] nr_of(input logic [1:0] mode);
        int nr;
        case (mode)
            KEY_128: nr = 10;
            KEY_192: nr = 12;
            default: nr = 14;
        endcase
        if (nr > MAX_ROUNDS) nr = MAX_ROUNDS;
        return RK_AW'(nr);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/aesbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module aesbc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/aesbc_keyexp.sv
// Key expansion sequencer: produces one round-key word per cycle and writes whole round keys.
`default_nettype none
module aesbc_keyexp import aesbc_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [255:0] key,
    input  wire logic [1:0]   mode,
    output rk_wr_t            wr,
    output logic              done
);

    logic              busy_reg, busy_next;
    logic [RK_WAW-1:0] idx_reg, idx_next;
    logic [3:0]        mod_reg, mod_next;
    logic [7:0]        rc_reg, rc_next;
    logic [31:0]       win_reg [8];
    logic [95:0]       row_reg;

    logic [3:0]        nk;
    logic [RK_WAW-1:0] last_idx;
    logic [31:0]       prev, back, t, word, rot;

    assign nk       = nk_of(mode);
    assign last_idx = RK_WAW'(4 * (int'(nr_of(mode)) + 1) - 1);
    assign prev     = win_reg[7];
    assign rot      = {prev[23:0], prev[31:24]};

    always_comb
    begin
        case (mode)
            KEY_128: back = win_reg[4];
            KEY_192: back = win_reg[2];
            default: back = win_reg[0];
        endcase
        t = prev;
        if (mod_reg == 4'd0)
        begin
            t = {sbox(rot[31:24]) ^ rc_reg, sbox(rot[23:16]), sbox(rot[15:8]), sbox(rot[7:0])};
        end
        else if (nk == 4'd8 && mod_reg == 4'd4)
        begin
            t = {sbox(prev[31:24]), sbox(prev[23:16]), sbox(prev[15:8]), sbox(prev[7:0])};
        end
        // The first nk words are the key itself, taken word by word.
        if (idx_reg < RK_WAW'(nk))
        begin
            word = key[{~idx_reg[2:0], 5'b00000} +: 32];
        end
        else
        begin
            word = back ^ t;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        mod_next  = mod_reg;
        rc_next   = rc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            mod_next  = '0;
            rc_next   = 8'h01;
        end
        else if (busy_reg)
        begin
            idx_next = idx_reg + RK_WAW'(1);
            mod_next = (mod_reg == nk - 4'd1) ? 4'd0 : mod_reg + 4'd1;
            if (idx_reg >= RK_WAW'(nk) && mod_reg == 4'd0)
            begin
                rc_next = xt(rc_reg);
            end
            if (idx_reg == last_idx)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            mod_reg  <= '0;
            rc_reg   <= 8'h01;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            mod_reg  <= mod_next;
            rc_reg   <= rc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            for (int j = 0; j < 7; j++)
            begin
                win_reg[j] <= win_reg[j+1];
            end
            win_reg[7] <= word;
            row_reg    <= {row_reg[63:0], word};
        end
    end

    assign wr.we   = busy_reg && (idx_reg[1:0] == 2'b11);
    assign wr.addr = idx_reg[RK_WAW-1:2];
    assign wr.data = {row_reg, word};
    assign done    = busy_reg && (idx_reg == last_idx);

endmodule
`default_nettype wire

FILE: rtl/aesbc_round.sv
// Shared cipher round: one forward or inverse AES round on the 128-bit state.
`default_nettype none
module aesbc_round import aesbc_pkg::*; (
    input  wire logic [127:0] state,
    input  wire logic [127:0] round_key,
    input  wire logic         dec,
    input  wire round_kind_t  kind,
    output logic      [127:0] result
);

    function automatic logic [7:0] gm9(input logic [7:0] a);
        logic [7:0] x2, x4, x8;
        x2 = xt(a); x4 = xt(x2); x8 = xt(x4);
        return x8 ^ a;
    endfunction

    function automatic logic [7:0] gm11(input logic [7:0] a);
        logic [7:0] x2, x4, x8;
        x2 = xt(a); x4 = xt(x2); x8 = xt(x4);
        return x8 ^ x2 ^ a;
    endfunction

    function automatic logic [7:0] gm13(input logic [7:0] a);
        logic [7:0] x2, x4, x8;
        x2 = xt(a); x4 = xt(x2); x8 = xt(x4);
        return x8 ^ x4 ^ a;
    endfunction

    function automatic logic [7:0] gm14(input logic [7:0] a);
        logic [7:0] x2, x4, x8;
        x2 = xt(a); x4 = xt(x2); x8 = xt(x4);
        return x8 ^ x4 ^ x2;
    endfunction

    logic [7:0]   b [16];
    logic [7:0]   s [16];
    logic [7:0]   m [16];
    logic [127:0] s_flat, a_flat, m_flat;

    // Byte k is row k mod 4 of column k div 4, byte 0 in the top bits.
    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            b[k] = state[127-8*k -: 8];
        end
        for (int k = 0; k < 16; k++)
        begin
            if (dec)
            begin
                s[k] = isbox(b[(k % 4) + 4 * (((k / 4) - (k % 4) + 4) % 4)]);
            end
            else
            begin
                s[k] = sbox(b[(k % 4) + 4 * (((k / 4) + (k % 4)) % 4)]);
            end
            s_flat[127-8*k -: 8] = s[k];
        end
        a_flat = s_flat ^ round_key;
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (dec)
                begin
                    m[4*c+i] = gm14(a_flat[127-8*(4*c+i) -: 8])
                             ^ gm11(a_flat[127-8*(4*c+(i+1)%4) -: 8])
                             ^ gm13(a_flat[127-8*(4*c+(i+2)%4) -: 8])
                             ^ gm9(a_flat[127-8*(4*c+(i+3)%4) -: 8]);
                end
                else
                begin
                    m[4*c+i] = xt(s[4*c+i])
                             ^ xt(s[4*c+(i+1)%4]) ^ s[4*c+(i+1)%4]
                             ^ s[4*c+(i+2)%4] ^ s[4*c+(i+3)%4];
                end
                m_flat[127-8*(4*c+i) -: 8] = m[4*c+i];
            end
        end
        case (kind)
            RK_FIRST: result = state ^ round_key;
            RK_LAST:  result = a_flat;
            RK_MID:   result = dec ? m_flat : (m_flat ^ round_key);
            default:  result = state;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/aes_block_cipher_ecb_cbc_top.sv
// Top level of the AES-128/192/256 block cipher with ECB and CBC chaining.
// One 128-bit block is taken per input beat and one result beat is returned for it. After any
// register write the first block first expands the key into the round-key RAM, one word per
// cycle: 44, 52 or 60 words for 128, 192 or 256 bit keys. A block then runs through the single
// round unit, applied once per round with its round key read from the RAM ahead of the round
// that uses it. The input is taken only while the sequencer is idle; a finished result waits
// in the output register while the next block is already accepted and worked on.
`default_nettype none
module aes_block_cipher_ecb_cbc_top import aesbc_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic      [63:0]  prdata,
    output logic              pready,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // block_high [63:0], block_low [127:64]
    input  wire logic [1:0]   s_axis_tuser,   // operation [0], restart_chain [1]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [127:0] m_axis_tdata    // result_high [63:0], result_low [127:64]
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXPAND = 5'b00010,
        S_PRIME  = 5'b00100,
        S_RUN    = 5'b01000,
        S_HOLD   = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [63:0]      key0_reg, key1_reg, key2_reg, key3_reg, ivh_reg, ivl_reg;
    logic [1:0]       klen_reg;
    logic             cbc_reg;
    logic             keys_ready_reg;
    logic [127:0]     chain_reg, used_reg, blk_reg, out_reg;
    logic             dec_reg, out_valid_reg;
    logic [RK_AW-1:0] step_reg, step_next;

    logic             cfg_wr, in_acc, out_free, exp_done;
    logic [2:0]       cfg_idx;
    logic [127:0]     blk, chain_eff, rk_data, round_out, res;
    logic [RK_AW-1:0] nr, rd_step, rd_addr;
    round_kind_t      kind;
    rk_wr_t           rk_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[5:3];
    assign nr       = nr_of(klen_reg);

    always_comb
    begin
        case (cfg_idx)
            REG_KEY0:  prdata = key0_reg;
            REG_KEY1:  prdata = key1_reg;
            REG_KEY2:  prdata = key2_reg;
            REG_KEY3:  prdata = key3_reg;
            REG_KLEN:  prdata = {62'd0, klen_reg};
            REG_CHAIN: prdata = {63'd0, cbc_reg};
            REG_IVH:   prdata = ivh_reg;
            REG_IVL:   prdata = ivl_reg;
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
            klen_reg <= 2'd2;
            cbc_reg  <= 1'b0;
            ivh_reg  <= '0;
            ivl_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_KEY0:  key0_reg <= pwdata;
                REG_KEY1:  key1_reg <= pwdata;
                REG_KEY2:  key2_reg <= pwdata;
                REG_KEY3:  key3_reg <= pwdata;
                REG_KLEN:  klen_reg <= pwdata[1:0];
                REG_CHAIN: cbc_reg  <= pwdata[0];
                REG_IVH:   ivh_reg  <= pwdata;
                REG_IVL:   ivl_reg  <= pwdata;
                default:   ;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign blk           = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign chain_eff     = (cbc_reg && s_axis_tuser[1]) ? {ivh_reg, ivl_reg} : chain_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // The round key for a step is read in the cycle before the step uses it.
    always_comb
    begin
        if (state_reg == S_RUN && step_reg != nr)
        begin
            rd_step = step_reg + RK_AW'(1);
        end
        else if (state_reg == S_RUN)
        begin
            rd_step = step_reg;
        end
        else
        begin
            rd_step = '0;
        end
        rd_addr = dec_reg ? (nr - rd_step) : rd_step;
        if (step_reg == '0)
        begin
            kind = RK_FIRST;
        end
        else if (step_reg == nr)
        begin
            kind = RK_LAST;
        end
        else
        begin
            kind = RK_MID;
        end
        res = (dec_reg && cbc_reg) ? (blk_reg ^ used_reg) : blk_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = keys_ready_reg ? S_PRIME : S_EXPAND;
                end
            end
            S_EXPAND:
            begin
                if (exp_done)
                begin
                    state_next = S_PRIME;
                end
            end
            S_PRIME:
            begin
                state_next = S_RUN;
                step_next  = '0;
            end
            S_RUN:
            begin
                if (step_reg == nr)
                begin
                    state_next = S_HOLD;
                end
                else
                begin
                    step_next = step_reg + RK_AW'(1);
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            keys_ready_reg <= 1'b0;
            chain_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_wr)
            begin
                keys_ready_reg <= 1'b0;
            end
            else if (exp_done)
            begin
                keys_ready_reg <= 1'b1;
            end
            if (in_acc && cbc_reg)
            begin
                chain_reg <= s_axis_tuser[0] ? blk : chain_eff;
            end
            else if (state_reg == S_HOLD && out_free && cbc_reg && !dec_reg)
            begin
                chain_reg <= res;
            end
            if (state_reg == S_HOLD && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            blk_reg  <= (cbc_reg && !s_axis_tuser[0]) ? (blk ^ chain_eff) : blk;
            used_reg <= chain_eff;
            dec_reg  <= s_axis_tuser[0];
        end
        else if (state_reg == S_RUN)
        begin
            blk_reg <= round_out;
        end
        if (state_reg == S_HOLD && out_free)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg[63:0], out_reg[127:64]};

    aesbc_keyexp u_keyexp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_acc && !keys_ready_reg),
        .key   ({key0_reg, key1_reg, key2_reg, key3_reg}),
        .mode  (klen_reg),
        .wr    (rk_wr),
        .done  (exp_done)
    );

    aesbc_ram #(
        .WIDTH (128),
        .DEPTH (RK_ROWS)
    ) u_rk_ram (
        .clk   (clk),
        .we    (rk_wr.we),
        .waddr (rk_wr.addr),
        .wdata (rk_wr.data),
        .raddr (rd_addr),
        .rdata (rk_data)
    );

    aesbc_round u_round (
        .state     (blk_reg),
        .round_key (rk_data),
        .dec       (dec_reg),
        .kind      (kind),
        .result    (round_out)
    );

endmodule
`default_nettype wire

FILE: rtl/aesbc_checker.sv
// Port-level checker for the AES block cipher top level, with its bind statement.
`default_nettype none
module aesbc_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         pready,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata
);

    // A stalled result beat keeps its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // Each block occupies the sequencer, so input beats are never taken back to back.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // No result can appear the cycle after a block is taken.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

endmodule

bind aes_block_cipher_ecb_cbc_top aesbc_checker u_aesbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: tb/tb_aes_block_cipher_ecb_cbc_top.sv
// Self-checking testbench for the AES ECB/CBC block cipher with its own AES predictor.
module tb_aes_block_cipher_ecb_cbc_top;
    import aesbc_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [5:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // block_high [63:0], block_low [127:64]
    logic [1:0]   s_axis_tuser;   // operation [0], restart_chain [1]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;   // result_high [63:0], result_low [127:64]

    aes_block_cipher_ecb_cbc_top dut (.*);

    // Predictor state.
    logic [7:0]   fwd_box [256];
    logic [7:0]   inv_box [256];
    logic [31:0]  sched [60];
    bit           sched_valid;
    logic [63:0]  key_reg [4];
    logic [1:0]   klen_reg;
    bit           cbc_on;
    logic [63:0]  iv_hi;
    logic [63:0]  iv_lo;
    logic [63:0]  chain_hi;
    logic [63:0]  chain_lo;
    logic [7:0]   state [16];
    logic [127:0] expected_blocks [$];

    int           errors;
    int           burst_left;
    int           hold_req;
    int           hold_ack;
    logic         in_ready_s;
    logic         out_valid_s;
    logic         out_ready_s;
    logic [127:0] out_data_s;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("tb_aes_block_cipher_ecb_cbc_top failed");
        $finish;
    end

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0]) p = p ^ a;
            a = xtime(a);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    function automatic int key_words_of(input logic [1:0] m);
        return m == KEY_128 ? 4 : (m == KEY_192 ? 6 : 8);
    endfunction

    function automatic int rounds_of(input logic [1:0] m);
        return m == KEY_128 ? 10 : (m == KEY_192 ? 12 : 14);
    endfunction

    function automatic logic [31:0] sub_word32(input logic [31:0] w);
        return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
    endfunction

    // The S-boxes are derived from the field inverse rather than copied in.
    task automatic build_boxes();
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h01;
            for (int i = 0; i < 254; i++) inv = gf_mul(inv, x[7:0]);
            if (x == 0) inv = 8'h00;
            s = inv ^ rot8(inv, 1) ^ rot8(inv, 2) ^ rot8(inv, 3) ^ rot8(inv, 4) ^ 8'h63;
            fwd_box[x] = s;
            inv_box[s] = x[7:0];
        end
    endtask

    task automatic expand_schedule();
        int nk;
        int total;
        logic [7:0] rcon;
        logic [31:0] t;
        nk = key_words_of(klen_reg);
        total = 4 * (rounds_of(klen_reg) + 1);
        rcon = 8'h01;
        for (int i = 0; i < nk; i++)
            sched[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
        for (int i = nk; i < total; i++)
        begin
            t = sched[i - 1];
            if (i % nk == 0)
            begin
                t = sub_word32({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = xtime(rcon);
            end
            else if (nk > 6 && i % nk == 4)
                t = sub_word32(t);
            sched[i] = sched[i - nk] ^ t;
        end
        sched_valid = 1'b1;
    endtask

    task automatic add_round_key(input int r);
        logic [31:0] w;
        for (int c = 0; c < 4; c++)
        begin
            w = sched[4 * r + c];
            state[4 * c]     ^= w[31:24];
            state[4 * c + 1] ^= w[23:16];
            state[4 * c + 2] ^= w[15:8];
            state[4 * c + 3] ^= w[7:0];
        end
    endtask

    // Byte k sits in row k%4, column k/4; rows rotate left to encrypt, right to decrypt.
    task automatic shift_and_sub(input bit inverse);
        logic [7:0] t [16];
        int dir;
        dir = inverse ? 3 : 1;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[r + 4 * c] = inverse ? inv_box[state[r + 4 * ((c + r * dir) & 3)]]
                                       : fwd_box[state[r + 4 * ((c + r * dir) & 3)]];
        state = t;
    endtask

    task automatic mix_columns(input bit inverse);
        logic [7:0] a [4];
        logic [7:0] m [4];
        if (inverse) m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else         m = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++) a[j] = state[4 * c + j];
            for (int j = 0; j < 4; j++)
                state[4 * c + j] = gf_mul(a[0], m[(4 - j) % 4]) ^ gf_mul(a[1], m[(5 - j) % 4])
                                 ^ gf_mul(a[2], m[(6 - j) % 4]) ^ gf_mul(a[3], m[(7 - j) % 4]);
        end
    endtask

    task automatic load_state(input logic [127:0] v);
        for (int k = 0; k < 16; k++) state[k] = v[127 - 8 * k -: 8];
    endtask

    function automatic logic [127:0] state_bits();
        logic [127:0] v;
        for (int k = 0; k < 16; k++) v[127 - 8 * k -: 8] = state[k];
        return v;
    endfunction

    task automatic cipher_block(input bit decrypt);
        int nr;
        nr = rounds_of(klen_reg);
        if (!decrypt)
        begin
            add_round_key(0);
            for (int r = 1; r < nr; r++)
            begin
                shift_and_sub(1'b0);
                mix_columns(1'b0);
                add_round_key(r);
            end
            shift_and_sub(1'b0);
            add_round_key(nr);
        end
        else
        begin
            add_round_key(nr);
            for (int r = nr - 1; r >= 1; r--)
            begin
                shift_and_sub(1'b1);
                add_round_key(r);
                mix_columns(1'b1);
            end
            shift_and_sub(1'b1);
            add_round_key(0);
        end
    endtask

    task automatic predict_block(input logic [63:0] hi, input logic [63:0] lo,
                                 input bit decrypt, input bit restart);
        logic [127:0] chain;
        logic [127:0] res;
        if (!sched_valid) expand_schedule();
        if (cbc_on && restart)
        begin
            chain_hi = iv_hi;
            chain_lo = iv_lo;
        end
        chain = {chain_hi, chain_lo};
        if (!decrypt)
        begin
            load_state(cbc_on ? ({hi, lo} ^ chain) : {hi, lo});
            cipher_block(1'b0);
            res = state_bits();
            if (cbc_on) {chain_hi, chain_lo} = res;
        end
        else
        begin
            load_state({hi, lo});
            cipher_block(1'b1);
            res = cbc_on ? (state_bits() ^ chain) : state_bits();
            if (cbc_on) {chain_hi, chain_lo} = {hi, lo};
        end
        expected_blocks.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // Beats are sampled at the falling edge ahead of the rising edge that takes them.
    always @(negedge clk)
    begin
        in_ready_s  = s_axis_tready;
        out_valid_s = m_axis_tvalid;
        out_ready_s = m_axis_tready;
        out_data_s  = m_axis_tdata;
    end

    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n && out_valid_s && out_ready_s)
        begin
            if (expected_blocks.size() == 0)
            begin
                $display("unexpected result beat %h", out_data_s);
                errors++;
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (out_data_s[63:0] !== want[127:64])
                    report_mismatch("result_high", out_data_s[63:0], want[127:64]);
                if (out_data_s[127:64] !== want[63:0])
                    report_mismatch("result_low", out_data_s[127:64], want[63:0]);
            end
        end
    end

    // Receiver: one of four stall styles at a time, plus long hold-offs on request.
    initial
    begin
        int style;
        int cyc;
        int hold_left;
        m_axis_tready = 1'b0;
        hold_ack = 0;
        hold_left = 0;
        cyc = 0;
        style = 0;
        forever
        begin
            @(posedge clk);
            if (cyc % 64 == 0) style = $urandom_range(0, 3);
            cyc++;
            if (hold_req != hold_ack)
            begin
                hold_ack = hold_req;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                case (style)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 4) == 0);
                    default: m_axis_tready <= (cyc % 7) < 3;
                endcase
        end
    end

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Called at a rising edge; returns at the edge that takes the beat, or after an idle gap that follows it.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input bit decrypt, input bit restart);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lo, hi};
        s_axis_tuser  <= {restart, decrypt};
        do @(posedge clk); while (!in_ready_s);
        predict_block(hi, lo, decrypt, restart);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_reg[idx[1:0]] = val;
            REG_KLEN:  klen_reg = val[1:0];
            REG_CHAIN: cbc_on = val[0];
            REG_IVH:   iv_hi = val;
            default:   iv_lo = val;
        endcase
        sched_valid = 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] klen, input bit cbc);
        drain();
        write_reg(REG_KEY0, pick_word());
        write_reg(REG_KEY1, pick_word());
        write_reg(REG_KEY2, pick_word());
        write_reg(REG_KEY3, pick_word());
        write_reg(REG_KLEN, {62'h0, klen});
        write_reg(REG_CHAIN, {63'h0, cbc});
        write_reg(REG_IVH, pick_word());
        write_reg(REG_IVL, pick_word());
    endtask

    // Reset state: AES-256 with an all-zero key, ECB, restart flag ignored.
    task automatic test_reset_defaults();
        send_block(64'h0, 64'h0, 1'b0, 1'b0);
        send_block('1, '1, 1'b1, 1'b1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, 1'b1);
    endtask

    // Every key length, including the unused code that behaves as AES-256.
    task automatic test_key_lengths();
        for (int m = 0; m < 4; m++)
        begin
            configure(m[1:0], 1'b0);
            send_block(64'h0, 64'h0, 1'b0, 1'b0);
            send_block('1, '1, 1'b1, 1'b0);
            send_block(pick_word(), pick_word(), 1'b0, 1'b1);
        end
    endtask

    // CBC with the zero chain after reset, then restarts in both directions.
    task automatic test_cbc_chaining();
        drain();
        write_reg(REG_CHAIN, 64'h1);
        send_block(pick_word(), pick_word(), 1'b0, 1'b0);
        send_block(pick_word(), pick_word(), 1'b0, 1'b0);
        send_block(pick_word(), pick_word(), 1'b0, 1'b1);
        send_block(pick_word(), pick_word(), 1'b0, 1'b0);
        send_block(pick_word(), pick_word(), 1'b1, 1'b1);
        send_block(pick_word(), pick_word(), 1'b1, 1'b0);
        send_block(pick_word(), pick_word(), 1'b1, 1'b0);
    endtask

    // Long receiver hold-off while blocks keep coming, then a full pause.
    task automatic test_backpressure();
        hold_req++;
        for (int i = 0; i < 8; i++)
            send_block(pick_word(), pick_word(), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        drain();
    endtask

    // Mostly well-formed CBC messages in one direction, some random flag noise.
    task automatic test_random_traffic();
        int sent;
        int len;
        bit dir;
        sent = 0;
        while (sent < 700)
        begin
            if (sent % 60 == 0)
                configure(2'($urandom_range(0, 3)), $urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) != 0)
            begin
                dir = 1'($urandom_range(0, 1));
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_block(pick_word(), pick_word(), dir, i == 0);
                sent += len;
            end
            else
            begin
                send_block(pick_word(), pick_word(), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    initial
    begin
        errors        = 0;
        burst_left    = 0;
        hold_req      = 0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        key_reg       = '{64'h0, 64'h0, 64'h0, 64'h0};
        klen_reg      = 2'd2;
        cbc_on        = 1'b0;
        iv_hi         = '0;
        iv_lo         = '0;
        chain_hi      = '0;
        chain_lo      = '0;
        sched_valid   = 1'b0;
        build_boxes();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_key_lengths();
        test_cbc_chaining();
        test_backpressure();
        test_random_traffic();
        drain();
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_blocks.size() == 0)
            $display("tb_aes_block_cipher_ecb_cbc_top passed");
        else
            $display("tb_aes_block_cipher_ecb_cbc_top failed");
        $finish;
    end

endmodule
